// File: hw/rtl/ple_pkg.sv
package ple_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } ple_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } ple_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_RESP
  } ple_state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [POS_W-1:0]          position;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
  } ple_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        entry_count;
    logic                      found;
    logic signed [FIELD_W-1:0] read_x;
    logic signed [FIELD_W-1:0] read_y;
  } ple_out_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ple_mem_ctl_t;

endpackage

// File: hw/rtl/ple_store.sv
module ple_store #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  ple_pkg::ple_mem_ctl_t        mem_ctl_i,
  input  logic [$clog2(CAPACITY)-1:0]  wr_addr_i,
  input  logic [2*COORD_BITS-1:0]      wr_data_i,
  input  logic [$clog2(CAPACITY)-1:0]  rd_addr_i,
  output logic [2*COORD_BITS-1:0]      rd_data_o
);
  import ple_pkg::*;

  logic [2*COORD_BITS-1:0] mem_q [CAPACITY];
  logic [2*COORD_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read word holds until the next read, so the controller can use it late.
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/ple_ctrl.sv
module ple_ctrl #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ple_pkg::ple_in_t             in_word_i,
  input  logic                         out_free_i,
  output logic                         resp_valid_o,
  output ple_pkg::ple_out_t            resp_o,
  output ple_pkg::ple_mem_ctl_t        mem_ctl_o,
  output logic [$clog2(CAPACITY)-1:0]  wr_addr_o,
  output logic [2*COORD_BITS-1:0]      wr_data_o,
  output logic [$clog2(CAPACITY)-1:0]  rd_addr_o,
  input  logic [2*COORD_BITS-1:0]      rd_data_i
);
  import ple_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = 2 * COORD_BITS;

  ple_state_e        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [1:0]        status_q, status_d;
  logic              found_q, found_d;
  logic              insert_q;
  logic [POS_W-1:0]  pos_q;
  logic [FIELD_W-1:0] px_q, py_q;
  logic              load;

  logic [CW-1:0]      neighbor;
  logic [COUNT_W-1:0] count_w;
  logic [COUNT_W-1:0] pos_w;
  logic [COUNT_W-1:0] neighbor_w;
  logic [COUNT_W-1:0] pos_q_w;
  logic [DW-1:0]      put_word;

  // Shared index unit: insert walks down from the end, remove walks up.
  assign neighbor   = insert_q ? idx_q - CW'(1) : idx_q + CW'(1);
  assign count_w    = COUNT_W'(count_q);
  assign pos_w      = COUNT_W'(in_word_i.position);
  assign pos_q_w    = COUNT_W'(pos_q);
  assign neighbor_w = COUNT_W'(neighbor);
  assign put_word   = {COORD_BITS'(px_q), COORD_BITS'(py_q)};
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    status_q <= status_d;
    found_q  <= found_d;
    if (load) begin
      insert_q <= (in_word_i.opcode == OP_INSERT);
      pos_q    <= in_word_i.position;
      px_q     <= in_word_i.point_x;
      py_q     <= in_word_i.point_y;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    status_d     = status_q;
    found_d      = found_q;
    load         = 1'b0;
    resp_valid_o = 1'b0;
    mem_ctl_o    = '0;
    wr_addr_o    = idx_q[AW-1:0];
    wr_data_o    = put_word;
    rd_addr_o    = neighbor[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load     = 1'b1;
          found_d  = 1'b0;
          status_d = STATUS_DONE;
          state_d  = ST_RESP;
          case (in_word_i.opcode)
            OP_APPEND: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = STATUS_FULL;
              end else begin
                idx_d   = count_q;
                state_d = ST_PUT;
              end
            end
            OP_INSERT: begin
              if (pos_w > count_w) begin
                status_d = STATUS_RANGE;
              end else if (count_q == CW'(CAPACITY)) begin
                status_d = STATUS_FULL;
              end else begin
                idx_d   = count_q;
                state_d = (count_w > pos_w) ? ST_SHIFT_RD : ST_PUT;
              end
            end
            OP_REMOVE: begin
              if (pos_w >= count_w) begin
                status_d = STATUS_RANGE;
              end else if (pos_w + COUNT_W'(1) < count_w) begin
                idx_d   = CW'(in_word_i.position);
                state_d = ST_SHIFT_RD;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            OP_READ: begin
              if (pos_w >= count_w) begin
                status_d = STATUS_RANGE;
              end else begin
                found_d         = 1'b1;
                mem_ctl_o.rd_en = 1'b1;
                rd_addr_o       = in_word_i.position[AW-1:0];
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
              status_d = STATUS_DONE;
            end
          endcase
        end
      end
      ST_SHIFT_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        state_d         = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_data_o       = rd_data_i;
        idx_d           = neighbor;
        if (insert_q) begin
          state_d = (neighbor_w > pos_q_w) ? ST_SHIFT_RD : ST_PUT;
        end else if (neighbor_w + COUNT_W'(1) < count_w) begin
          state_d = ST_SHIFT_RD;
        end else begin
          count_d = count_q - CW'(1);
          state_d = ST_RESP;
        end
      end
      ST_PUT: begin
        mem_ctl_o.wr_en = 1'b1;
        count_d         = count_q + CW'(1);
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        if (out_free_i) begin
          resp_valid_o = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    resp_o.status      = status_q;
    resp_o.entry_count = count_w;
    resp_o.found       = found_q;
    resp_o.read_x      = found_q ? FIELD_W'(rd_data_i[DW-1:COORD_BITS]) : '0;
    resp_o.read_y      = found_q ? FIELD_W'(rd_data_i[COORD_BITS-1:0]) : '0;
  end

endmodule

// File: hw/rtl/point_list_engine_unit.sv
// Ordered list of up to CAPACITY points with append, insert, remove, read and
// clear. One word enters on the input channel (in_valid_i / in_stall_o) and
// exactly one result word leaves on the output channel (out_valid_o /
// out_stall_i). A word moves at a clock edge where valid is high and stall is
// low.
// The block works on one word at a time; in_stall_o stays high from the
// accepting edge until the result has been handed to the output register.
// With n the count and p the position: read, clear, rejected words and unused
// opcodes go straight to the result; append writes the point; insert moves
// entries p to n-1 up one place, last first, then writes the point; remove
// moves the entries above p down one place. The next word can be taken in the
// cycle after the result is registered. Each moved entry takes one read and
// one write of the point memory through the shared index stepper.
// The output register lets a new word be taken while a result still waits.
// If the receiver stalls, the result holds on out_word_o and a finished
// word waits inside the block until the register frees.
// Reset empties the list and clears out_valid_o; the point memory is not
// cleared, since only positions below the count are ever read.
module point_list_engine_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ple_pkg::ple_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ple_pkg::ple_out_t out_word_o
);
  import ple_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned DW = 2 * COORD_BITS;

  ple_mem_ctl_t mem_ctl;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] wr_data;
  logic [DW-1:0] rd_data;
  logic          resp_valid;
  ple_out_t      resp;
  logic          out_free;
  logic          out_valid_q;
  ple_out_t      out_word_q;

  assign out_free = !out_valid_q || !out_stall_i;

  ple_ctrl #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_free_i  (out_free),
    .resp_valid_o(resp_valid),
    .resp_o      (resp),
    .mem_ctl_o   (mem_ctl),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  ple_store #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .mem_ctl_i(mem_ctl),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_valid) begin
      out_word_q <= resp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The count reported never goes past the list size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.entry_count <= COUNT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

  // A read that hits always reports success.
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.found) |-> (out_word_o.status == STATUS_DONE))
    else $error("found set with failing status");

  // Point fields are zero unless a read hit.
  a_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.found) |->
      (out_word_o.read_x == '0 && out_word_o.read_y == '0))
    else $error("point fields set without a hit");

  // Once a word is taken the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice in a row");

endmodule
